// ===== rtl/core/pll_pkg.sv =====
package pll_pkg;

	localparam int POOL_NODES = 64;
	localparam int NUM_LISTS  = 4;
	localparam int KEY_W      = 32;
	localparam int IDX_W      = $clog2(POOL_NODES);
	localparam int PTR_W      = $clog2(POOL_NODES + 1);
	localparam int LIST_W     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CNT_W      = 7;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_APPEND = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_FULL    = 3'd2,
		ST_MISSING = 3'd3,
		ST_NULL    = 3'd4
	} status_t;

	function automatic logic in_pool(input logic [PTR_W-1:0] p);
		return p < NIL;
	endfunction

endpackage

// ===== rtl/core/pooled_linked_list_set.sv =====
// Several insertion-ordered lists of nonzero keys sharing one pool of node memory.
// Pulse start while busy is low to issue an item (op, list_id, key); busy stays high
// until the result is out, and done marks status, list_empty and list_size for one
// cycle with no way to hold it, so capture it then. After reset the block runs a
// pass over all 64 nodes that chains the free list and stays busy meanwhile. Init
// and query go from the accepting state straight to the response state.
// Append and remove walk the list one node per cycle through the single read port of
// the node memory. A second item can be issued the cycle done is high.
module pooled_linked_list_set (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 op,
	input  logic [1:0]                 list_id,
	input  logic [pll_pkg::KEY_W-1:0]  key,
	output logic                       done,
	output logic [2:0]                 status,
	output logic                       list_empty,
	output logic [pll_pkg::CNT_W-1:0]  list_size
);
	import pll_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_WALK   = 10'b0000000100,
		S_ALLOC  = 10'b0000001000,
		S_TAKE   = 10'b0000010000,
		S_LINK   = 10'b0000100000,
		S_UNLINK = 10'b0001000000,
		S_FREE   = 10'b0010000000,
		S_RESP   = 10'b0100000000,
		S_MISS   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [KEY_W-1:0] node_key [POOL_NODES];
	logic [PTR_W-1:0] node_link [POOL_NODES];
	logic [KEY_W-1:0] key_rd_q;
	logic [PTR_W-1:0] link_rd_q;

	logic [PTR_W-1:0] list_head_q [NUM_LISTS];
	logic [PTR_W-1:0] list_tail_q [NUM_LISTS];
	logic [CNT_W-1:0] list_count_q [NUM_LISTS];
	logic [PTR_W-1:0] free_head_q;

	op_t              op_q;
	logic [LIST_W-1:0] l_q;
	logic [KEY_W-1:0] key_q;
	logic [PTR_W-1:0] cur_q;
	logic [PTR_W-1:0] prev_q;
	logic [PTR_W-1:0] nxt_q;
	logic [PTR_W-1:0] steps_q;
	logic [IDX_W-1:0] clr_idx_q;
	status_t          status_q;

	logic              done_q;
	logic              empty_q;
	logic [CNT_W-1:0]  size_q;

	logic [LIST_W-1:0] l_in;
	logic [IDX_W-1:0]  rd_addr;
	logic              link_we;
	logic [IDX_W-1:0]  link_wa;
	logic [PTR_W-1:0]  link_wd;
	logic              key_we;
	logic [PTR_W-1:0]  steps_inc;
	logic              hit;

	assign l_in      = LIST_W'(list_id % NUM_LISTS);
	assign steps_inc = steps_q + PTR_W'(1);
	assign hit       = (key_rd_q == key_q);
	assign key_we    = (state_q == S_TAKE);

	always_comb begin
		rd_addr = cur_q[IDX_W-1:0];
		link_we = 1'b0;
		link_wa = cur_q[IDX_W-1:0];
		link_wd = NIL;
		unique case (state_q)
			S_IDLE:  rd_addr = list_head_q[l_in][IDX_W-1:0];
			S_WALK:  rd_addr = link_rd_q[IDX_W-1:0];
			S_ALLOC: rd_addr = free_head_q[IDX_W-1:0];
			S_CLEAR: begin
				link_we = 1'b1;
				link_wa = clr_idx_q;
				link_wd = PTR_W'(clr_idx_q) + PTR_W'(1);
			end
			S_TAKE: begin
				link_we = 1'b1;
			end
			S_LINK: begin
				link_we = 1'b1;
				link_wa = prev_q[IDX_W-1:0];
				link_wd = cur_q;
			end
			S_UNLINK: begin
				link_we = in_pool(prev_q);
				link_wa = prev_q[IDX_W-1:0];
				link_wd = nxt_q;
			end
			S_FREE: begin
				link_we = 1'b1;
				link_wd = free_head_q;
			end
			default: begin
			end
		endcase
	end

	// node memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (link_we) begin
			node_link[link_wa] <= link_wd;
		end
		if (key_we) begin
			node_key[cur_q[IDX_W-1:0]] <= key_q;
		end
		link_rd_q <= node_link[rd_addr];
		key_rd_q  <= node_key[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			free_head_q <= '0;
			done_q      <= 1'b0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				list_head_q[i]  <= NIL;
				list_tail_q[i]  <= NIL;
				list_count_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(POOL_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q     <= op_t'(op);
						l_q      <= l_in;
						key_q    <= key;
						cur_q    <= list_head_q[l_in];
						prev_q   <= NIL;
						steps_q  <= '0;
						status_q <= ST_OK;
						state_q  <= S_RESP;
						if (op_t'(op) == OP_INIT) begin
							list_head_q[l_in]  <= NIL;
							list_tail_q[l_in]  <= NIL;
							list_count_q[l_in] <= '0;
						end else if (op_t'(op) == OP_APPEND || op_t'(op) == OP_REMOVE) begin
							if (key == '0) begin
								status_q <= ST_NULL;
							end else if (in_pool(list_head_q[l_in])) begin
								state_q <= S_WALK;
							end else if (op_t'(op) == OP_APPEND) begin
								state_q <= S_ALLOC;
							end else begin
								state_q <= S_MISS;
							end
						end
					end
				end
				S_WALK: begin
					if (hit) begin
						if (op_q == OP_APPEND) begin
							status_q <= ST_DUP;
							state_q  <= S_RESP;
						end else begin
							nxt_q   <= link_rd_q;
							state_q <= S_UNLINK;
						end
					end else if (steps_inc < NIL && in_pool(link_rd_q)) begin
						// advance to the next node; its read is already issued
						prev_q  <= cur_q;
						cur_q   <= link_rd_q;
						steps_q <= steps_inc;
					end else if (op_q == OP_APPEND) begin
						state_q <= S_ALLOC;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					status_q <= ST_MISSING;
					state_q  <= S_RESP;
				end
				S_ALLOC: begin
					cur_q <= free_head_q;
					if (in_pool(free_head_q)) begin
						state_q <= S_TAKE;
					end else begin
						status_q <= ST_FULL;
						state_q  <= S_RESP;
					end
				end
				S_TAKE: begin
					free_head_q <= link_rd_q;
					if (!in_pool(list_head_q[l_q]) || !in_pool(list_tail_q[l_q])) begin
						list_head_q[l_q]  <= cur_q;
						list_tail_q[l_q]  <= cur_q;
						list_count_q[l_q] <= list_count_q[l_q] + CNT_W'(1);
						state_q           <= S_RESP;
					end else begin
						prev_q  <= list_tail_q[l_q];
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					list_tail_q[l_q]  <= cur_q;
					list_count_q[l_q] <= list_count_q[l_q] + CNT_W'(1);
					state_q           <= S_RESP;
				end
				S_UNLINK: begin
					state_q <= S_FREE;
				end
				S_FREE: begin
					free_head_q <= cur_q;
					if (list_count_q[l_q] <= CNT_W'(1)) begin
						// list drained: drop head and tail
						list_count_q[l_q] <= '0;
						list_head_q[l_q]  <= NIL;
						list_tail_q[l_q]  <= NIL;
					end else begin
						list_count_q[l_q] <= list_count_q[l_q] - CNT_W'(1);
						if (!in_pool(prev_q)) begin
							list_head_q[l_q] <= nxt_q;
						end
						if (cur_q == list_tail_q[l_q]) begin
							list_tail_q[l_q] <= prev_q;
						end
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP) begin
			empty_q <= (list_count_q[l_q] == '0);
			size_q  <= list_count_q[l_q];
		end
	end

	logic [2:0] status_out_q;

	always_ff @(posedge clk) begin
		if (state_q == S_RESP) begin
			status_out_q <= status_q;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_out_q;
	assign list_empty = empty_q;
	assign list_size  = size_q;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	import pll_pkg::*;

	localparam int NIL_IDX      = POOL_NODES;
	localparam int RANDOM_ITEMS = 880;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 80;

	typedef struct {
		status_t           status;
		logic              empty;
		logic [CNT_W-1:0]  size;
	} list_reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        op = OP_INIT;
	logic [1:0]        list_id = '0;
	logic [KEY_W-1:0]  key = '0;
	logic              busy;
	logic              done;
	logic [2:0]        status;
	logic              list_empty;
	logic [CNT_W-1:0]  list_size;

	// shadow copy of the node pool and the lists
	logic [KEY_W-1:0]  pool_key [POOL_NODES];
	int                pool_next [POOL_NODES];
	int                free_top;
	int                free_count;
	int                head_of [NUM_LISTS];
	int                tail_of [NUM_LISTS];
	int                size_of [NUM_LISTS];

	list_reply_t       pending_replies [$];
	int                fail_count = 0;
	int                steady_run = 0;
	int                stall_cycles;

	pooled_linked_list_set u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.list_id    (list_id),
		.key        (key),
		.done       (done),
		.status     (status),
		.list_empty (list_empty),
		.list_size  (list_size)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_lists();
		for (int i = 0; i < POOL_NODES; i++) begin
			pool_key[i]  = '0;
			pool_next[i] = i + 1;
		end
		free_top   = 0;
		free_count = POOL_NODES;
		for (int i = 0; i < NUM_LISTS; i++) begin
			head_of[i] = NIL_IDX;
			tail_of[i] = NIL_IDX;
			size_of[i] = 0;
		end
	endfunction

	function automatic status_t apply_item(op_t o, int l, logic [KEY_W-1:0] k);
		int      cur;
		int      prev;
		int      nxt;
		int      steps;
		int      n;
		bit      found;
		status_t st;
		st    = ST_OK;
		cur   = head_of[l];
		prev  = NIL_IDX;
		steps = 0;
		found = 1'b0;
		case (o)
			OP_INIT: begin
				// nodes of the list stay out of the pool
				head_of[l] = NIL_IDX;
				tail_of[l] = NIL_IDX;
				size_of[l] = 0;
			end
			OP_APPEND: begin
				if (k == '0) begin
					st = ST_NULL;
				end else begin
					while (st == ST_OK && steps < POOL_NODES && cur < POOL_NODES) begin
						if (pool_key[cur] == k)
							st = ST_DUP;
						cur = pool_next[cur];
						steps++;
					end
					if (st == ST_OK && free_top >= POOL_NODES) begin
						st = ST_FULL;
					end else if (st == ST_OK) begin
						n            = free_top;
						free_top     = pool_next[n];
						free_count--;
						pool_key[n]  = k;
						pool_next[n] = NIL_IDX;
						if (head_of[l] >= POOL_NODES || tail_of[l] >= POOL_NODES)
							head_of[l] = n;
						else
							pool_next[tail_of[l]] = n;
						tail_of[l] = n;
						size_of[l]++;
					end
				end
			end
			OP_REMOVE: begin
				if (k == '0) begin
					st = ST_NULL;
				end else begin
					while (!found && steps < POOL_NODES && cur < POOL_NODES) begin
						if (pool_key[cur] == k) begin
							found = 1'b1;
						end else begin
							prev = cur;
							cur  = pool_next[cur];
							steps++;
						end
					end
					if (!found) begin
						st = ST_MISSING;
					end else begin
						nxt = pool_next[cur];
						if (prev >= POOL_NODES)
							head_of[l] = nxt;
						else
							pool_next[prev] = nxt;
						if (cur == tail_of[l])
							tail_of[l] = prev;
						pool_next[cur] = free_top;
						free_top       = cur;
						free_count++;
						if (size_of[l] > 0)
							size_of[l]--;
						if (size_of[l] == 0) begin
							head_of[l] = NIL_IDX;
							tail_of[l] = NIL_IDX;
						end
					end
				end
			end
			default: ;
		endcase
		return st;
	endfunction

	// an empty list or a position past the end gives the null key
	function automatic logic [KEY_W-1:0] key_at(int l, int pos);
		int cur;
		cur = head_of[l];
		repeat (pos) begin
			if (cur < POOL_NODES)
				cur = pool_next[cur];
		end
		if (cur >= POOL_NODES)
			return '0;
		return pool_key[cur];
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(int l, bit hit);
		int r;
		r = $urandom_range(99);
		if (hit && size_of[l] > 0 && r < 60)
			return key_at(l, $urandom_range(size_of[l] - 1));
		r = $urandom_range(99);
		if (r < 4)
			return '0;
		if (r < 7)
			return '1;
		if (r < 9)
			return {1'b1, {(KEY_W-1){1'b0}}};
		if (r < 20)
			return KEY_W'($urandom());
		return KEY_W'($urandom_range(40, 1));
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_run > 0) begin
			steady_run--;
			return 0;
		end
		r = $urandom_range(999);
		if (r < 20) begin
			steady_run = $urandom_range(60, 30);
			return 0;
		end
		if (r < 450)
			return 0;
		if (r < 850)
			return $urandom_range(3, 1);
		if (r < 970)
			return $urandom_range(12, 4);
		return $urandom_range(120, 30);
	endfunction

	// call at a rising edge; leaves start high once the item is taken
	task automatic send_item(op_t o, logic [1:0] lid, logic [KEY_W-1:0] k);
		int          gap;
		int          l;
		list_reply_t r;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		op      <= o;
		list_id <= lid;
		key     <= k;
		do @(posedge clk); while (busy);
		l        = int'(lid) % NUM_LISTS;
		r.status = apply_item(o, l, k);
		r.empty  = (size_of[l] == 0);
		r.size   = CNT_W'(size_of[l]);
		pending_replies.push_back(r);
	endtask

	task automatic wait_all_replies();
		start <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic test_directed_cases();
		send_item(OP_QUERY,  2'd0, '0);
		send_item(OP_APPEND, 2'd0, '0);
		send_item(OP_REMOVE, 2'd0, '0);
		send_item(OP_REMOVE, 2'd0, KEY_W'(5));
		send_item(OP_APPEND, 2'd0, '1);
		send_item(OP_APPEND, 2'd0, {1'b1, {(KEY_W-1){1'b0}}});
		send_item(OP_APPEND, 2'd0, KEY_W'(1));
		send_item(OP_APPEND, 2'd0, '1);
		send_item(OP_QUERY,  2'd0, KEY_W'(32'h1234_5678));
		// unlink from the middle, then the head, then the last one
		send_item(OP_REMOVE, 2'd0, {1'b1, {(KEY_W-1){1'b0}}});
		send_item(OP_REMOVE, 2'd0, '1);
		send_item(OP_REMOVE, 2'd0, KEY_W'(1));
		send_item(OP_APPEND, 2'd3, KEY_W'(7));
		send_item(OP_APPEND, 2'd3, KEY_W'(9));
		send_item(OP_APPEND, 2'd2, KEY_W'(7));
		send_item(OP_REMOVE, 2'd3, KEY_W'(9));
		send_item(OP_APPEND, 2'd3, KEY_W'(11));
		send_item(OP_INIT,   2'd3, KEY_W'(123));
		send_item(OP_APPEND, 2'd3, KEY_W'(9));
		send_item(OP_QUERY,  2'd1, '0);
		send_item(OP_INIT,   2'd1, '1);
		send_item(OP_QUERY,  2'd3, '1);
	endtask

	task automatic test_random_traffic();
		int               l;
		int               r;
		op_t              o;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_all_replies();
			l = $urandom_range(NUM_LISTS - 1);
			r = $urandom_range(99);
			// limit how many nodes a clear may leak
			if (r < 4 && (size_of[l] == 0 || free_count >= 48))
				o = OP_INIT;
			else if (r < 10)
				o = OP_QUERY;
			else if ($urandom_range(99) < (free_count > 20 ? 58 : 38))
				o = OP_APPEND;
			else
				o = OP_REMOVE;
			if (o == OP_INIT || o == OP_QUERY)
				k = KEY_W'($urandom());
			else
				k = pick_key(l, o == OP_REMOVE);
			send_item(o, 2'(l), k);
		end
	endtask

	task automatic test_pool_exhaustion();
		int n;
		wait_all_replies();
		n = 0;
		while (free_count > 0) begin
			send_item(OP_APPEND, 2'(n % NUM_LISTS), KEY_W'(32'h5A00_0000 + n));
			n++;
		end
		send_item(OP_APPEND, 2'd1, KEY_W'(32'h7700_0001));
		send_item(OP_APPEND, 2'd2, key_at(2, size_of[2] - 1));
		send_item(OP_REMOVE, 2'd2, key_at(2, 0));
		send_item(OP_APPEND, 2'd0, KEY_W'(32'h7700_0002));
		send_item(OP_APPEND, 2'd1, KEY_W'(32'h7700_0003));
		// cleared nodes do not come back
		send_item(OP_INIT,   2'd3, '0);
		send_item(OP_APPEND, 2'd3, KEY_W'(32'h7700_0004));
		send_item(OP_QUERY,  2'd3, '0);
	endtask

	always @(posedge clk) begin
		list_reply_t want;
		if (done) begin
			if (pending_replies.size() == 0) begin
				$error("result with nothing pending: status %0d, list_size %0d",
					status, list_size);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (list_empty !== want.empty) begin
					$error("list_empty: expected %0d, got %0d", want.empty, list_empty);
					fail_count++;
				end
				if (list_size !== want.size) begin
					$error("list_size: expected %0d, got %0d", want.size, list_size);
					fail_count++;
				end
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		clear_lists();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_traffic();
		test_pool_exhaustion();
		wait_all_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
